### sv/phb_pkg.sv
// Shared codes and control types for the point hitbox test block.
package phb_pkg;

    localparam int IDX_BITS = 3;
    localparam int CNT_BITS = 4;
    localparam int SHAPE_BITS = 2;
    localparam int ADDR_BITS = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [SHAPE_BITS-1:0] SHAPE_NONE = 2'd0;
    localparam logic [SHAPE_BITS-1:0] SHAPE_CIRCLE = 2'd1;
    localparam logic [SHAPE_BITS-1:0] SHAPE_RECT = 2'd2;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_POS_X = 2'd0,
        REG_POS_Y = 2'd1,
        REG_BOX_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                  valid;
        logic                  query;
        logic [IDX_BITS-1:0]   index;
        logic [SHAPE_BITS-1:0] shape;
        logic                  hit;
    } phb_ctl_t;

endpackage

### sv/point_hitbox_test.sv
// Point hit test against a chain of hitbox cells, one table entry per cell.
//
//   channel | signals                        | moves
//   --------+--------------------------------+-------------------------------
//   s       | s_tvalid s_tready s_tdata s_tuser | write or query request
//   m       | m_tvalid m_tready m_tdata      | hit result, queries only
//   cfg     | cfg_we cfg_addr cfg_wdata      | pos_x, pos_y, box_count
//
// One request enters per cycle while s_tready is high; a query passes each cell's
// s1-s3 registers and the output register before m_tvalid rises. Writes travel the
// same chain and load their cell on arrival. Reset clears all shapes to none and
// empties the chain. A held result with m_tready low freezes the whole chain.
module point_hitbox_test
    import phb_pkg::*;
#(
    parameter int MAX_BOXES = 8,
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index, box_kind, off_x, off_y, radius, box_length, box_height,
    // point_x, point_y, zero fill
    input  logic [((7*COORD_BITS+2+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit, zero fill
    output logic [7:0]            m_tdata,
    input  logic                  cfg_we,
    input  logic [ADDR_BITS-1:0]  cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_wdata
);

    localparam int RW = COORD_BITS - 1;
    localparam int IDX_LO = 0;
    localparam int KIND_LO = IDX_LO + IDX_BITS;
    localparam int OFFX_LO = KIND_LO + SHAPE_BITS;
    localparam int OFFY_LO = OFFX_LO + COORD_BITS;
    localparam int RAD_LO = OFFY_LO + COORD_BITS;
    localparam int LEN_LO = RAD_LO + RW;
    localparam int HGT_LO = LEN_LO + RW;
    localparam int PX_LO = HGT_LO + RW;
    localparam int PY_LO = PX_LO + COORD_BITS;

    logic signed [COORD_BITS-1:0] pos_x_reg;
    logic signed [COORD_BITS-1:0] pos_y_reg;
    logic [CNT_BITS-1:0]          box_count_reg;
    logic                         out_valid_reg;
    logic                         out_hit_reg;
    logic                         adv;
    logic [MAX_BOXES-1:0]         active;

    phb_ctl_t                     ctl_chain [0:MAX_BOXES];
    logic signed [COORD_BITS-1:0] a_chain [0:MAX_BOXES];
    logic signed [COORD_BITS-1:0] b_chain [0:MAX_BOXES];
    logic [RW-1:0]                r_chain [0:MAX_BOXES];
    logic [RW-1:0]                w_chain [0:MAX_BOXES];
    logic [RW-1:0]                h_chain [0:MAX_BOXES];

    assign adv = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            box_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_POS_X:     pos_x_reg     <= cfg_wdata;
                REG_POS_Y:     pos_y_reg     <= cfg_wdata;
                REG_BOX_COUNT: box_count_reg <= cfg_wdata[CNT_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        ctl_chain[0].valid = s_tvalid;
        ctl_chain[0].query = s_tuser;
        ctl_chain[0].index = s_tdata[IDX_LO +: IDX_BITS];
        ctl_chain[0].shape = s_tdata[KIND_LO +: SHAPE_BITS];
        ctl_chain[0].hit   = 1'b0;
        a_chain[0] = (s_tuser == KIND_QUERY) ? s_tdata[PX_LO +: COORD_BITS]
                                             : s_tdata[OFFX_LO +: COORD_BITS];
        b_chain[0] = (s_tuser == KIND_QUERY) ? s_tdata[PY_LO +: COORD_BITS]
                                             : s_tdata[OFFY_LO +: COORD_BITS];
        r_chain[0] = s_tdata[RAD_LO +: RW];
        w_chain[0] = s_tdata[LEN_LO +: RW];
        h_chain[0] = s_tdata[HGT_LO +: RW];
    end

    for (genvar k = 0; k < MAX_BOXES; k++)
    begin : g_cell
        assign active[k] = {3'b000, box_count_reg} > 7'(k);

        phb_cell #(
            .COORD_BITS (COORD_BITS),
            .CELL_ID    (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .active  (active[k]),
            .pos_x   (pos_x_reg),
            .pos_y   (pos_y_reg),
            .in_ctl  (ctl_chain[k]),
            .in_a    (a_chain[k]),
            .in_b    (b_chain[k]),
            .in_r    (r_chain[k]),
            .in_w    (w_chain[k]),
            .in_h    (h_chain[k]),
            .out_ctl (ctl_chain[k+1]),
            .out_a   (a_chain[k+1]),
            .out_b   (b_chain[k+1]),
            .out_r   (r_chain[k+1]),
            .out_w   (w_chain[k+1]),
            .out_h   (h_chain[k+1])
        );
    end

    // Drop writes at the chain end; hold query results until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_chain[MAX_BOXES].valid
                             && (ctl_chain[MAX_BOXES].query == KIND_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg <= ctl_chain[MAX_BOXES].hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_hit_reg};

endmodule

### sv/phb_cell.sv
// One hitbox entry with its three-stage test slice; requests pass to the next cell.
module phb_cell
    import phb_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int CELL_ID = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         active,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  phb_ctl_t                     in_ctl,
    input  logic signed [COORD_BITS-1:0] in_a,
    input  logic signed [COORD_BITS-1:0] in_b,
    input  logic [COORD_BITS-2:0]        in_r,
    input  logic [COORD_BITS-2:0]        in_w,
    input  logic [COORD_BITS-2:0]        in_h,
    output phb_ctl_t                     out_ctl,
    output logic signed [COORD_BITS-1:0] out_a,
    output logic signed [COORD_BITS-1:0] out_b,
    output logic [COORD_BITS-2:0]        out_r,
    output logic [COORD_BITS-2:0]        out_w,
    output logic [COORD_BITS-2:0]        out_h
);

    localparam int RW = COORD_BITS - 1;
    localparam int DW = COORD_BITS + 2;
    localparam int SQ = 2 * COORD_BITS + 2;
    localparam int SUMW = SQ + 1;
    localparam int R2W = 2 * RW;
    localparam bit CAN_WRITE = CELL_ID < (1 << IDX_BITS);

    logic [SHAPE_BITS-1:0]        shape_reg;
    logic signed [COORD_BITS-1:0] offx_reg;
    logic signed [COORD_BITS-1:0] offy_reg;
    logic [RW-1:0]                rad_reg;
    logic [RW-1:0]                wid_reg;
    logic [RW-1:0]                tall_reg;
    logic                         write_sel;

    phb_ctl_t                     s1_ctl_reg;
    logic signed [COORD_BITS-1:0] s1_a_reg;
    logic signed [COORD_BITS-1:0] s1_b_reg;
    logic [RW-1:0]                s1_r_reg;
    logic [RW-1:0]                s1_w_reg;
    logic [RW-1:0]                s1_h_reg;
    logic signed [DW-1:0]         s1_dx_reg;
    logic signed [DW-1:0]         s1_dy_reg;
    logic signed [DW-1:0]         s1_dx_next;
    logic signed [DW-1:0]         s1_dy_next;
    logic signed [2*DW-1:0]       s1_dx_sq;
    logic signed [2*DW-1:0]       s1_dy_sq;
    logic [SHAPE_BITS-1:0]        s1_shape_reg;
    logic [RW-1:0]                s1_rad_reg;
    logic [RW-1:0]                s1_wid_reg;
    logic [RW-1:0]                s1_tall_reg;

    phb_ctl_t                     s2_ctl_reg;
    logic signed [COORD_BITS-1:0] s2_a_reg;
    logic signed [COORD_BITS-1:0] s2_b_reg;
    logic [RW-1:0]                s2_r_reg;
    logic [RW-1:0]                s2_w_reg;
    logic [RW-1:0]                s2_h_reg;
    logic [SQ-1:0]                s2_sqx_reg;
    logic [SQ-1:0]                s2_sqy_reg;
    logic [R2W-1:0]               s2_r2_reg;
    logic                         s2_circ_reg;
    logic                         s2_rect_reg;
    logic                         s2_rect_next;

    phb_ctl_t                     s3_ctl_reg;
    phb_ctl_t                     s3_ctl_next;
    logic signed [COORD_BITS-1:0] s3_a_reg;
    logic signed [COORD_BITS-1:0] s3_b_reg;
    logic [RW-1:0]                s3_r_reg;
    logic [RW-1:0]                s3_w_reg;
    logic [RW-1:0]                s3_h_reg;
    logic [SUMW-1:0]              s3_sum;
    logic                         s3_hit_next;

    assign write_sel = CAN_WRITE && in_ctl.valid && (in_ctl.query == KIND_WRITE)
                       && (in_ctl.index == IDX_BITS'(CELL_ID));

    assign s1_dx_next = DW'(in_a) - DW'(pos_x) - DW'(offx_reg);
    assign s1_dy_next = DW'(in_b) - DW'(pos_y) - DW'(offy_reg);

    assign s1_dx_sq = s1_dx_reg * s1_dx_reg;
    assign s1_dy_sq = s1_dy_reg * s1_dy_reg;

    assign s2_rect_next = (s1_shape_reg == SHAPE_RECT)
                          && !s1_dx_reg[DW-1] && (s1_dx_reg <= $signed({3'b000, s1_wid_reg}))
                          && !s1_dy_reg[DW-1] && (s1_dy_reg <= $signed({3'b000, s1_tall_reg}));

    assign s3_sum = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
    assign s3_hit_next = s2_ctl_reg.hit || s2_rect_reg
                         || (s2_circ_reg && (s3_sum < SUMW'(s2_r2_reg)));

    always_comb
    begin
        s3_ctl_next     = s2_ctl_reg;
        s3_ctl_next.hit = s3_hit_next;
    end

    // Entry shape resets to none; the rest is undefined until written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= SHAPE_NONE;
        end
        else if (adv && write_sel)
        begin
            shape_reg <= in_ctl.shape;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && write_sel)
        begin
            offx_reg <= in_a;
            offy_reg <= in_b;
            rad_reg  <= in_r;
            wid_reg  <= in_w;
            tall_reg <= in_h;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s3_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg     <= in_a;
            s1_b_reg     <= in_b;
            s1_r_reg     <= in_r;
            s1_w_reg     <= in_w;
            s1_h_reg     <= in_h;
            s1_dx_reg    <= s1_dx_next;
            s1_dy_reg    <= s1_dy_next;
            s1_shape_reg <= active ? shape_reg : SHAPE_NONE;
            s1_rad_reg   <= rad_reg;
            s1_wid_reg   <= wid_reg;
            s1_tall_reg  <= tall_reg;

            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_r_reg    <= s1_r_reg;
            s2_w_reg    <= s1_w_reg;
            s2_h_reg    <= s1_h_reg;
            s2_sqx_reg  <= s1_dx_sq[SQ-1:0];
            s2_sqy_reg  <= s1_dy_sq[SQ-1:0];
            s2_r2_reg   <= R2W'(s1_rad_reg) * R2W'(s1_rad_reg);
            s2_circ_reg <= (s1_shape_reg == SHAPE_CIRCLE);
            s2_rect_reg <= s2_rect_next;

            s3_a_reg <= s2_a_reg;
            s3_b_reg <= s2_b_reg;
            s3_r_reg <= s2_r_reg;
            s3_w_reg <= s2_w_reg;
            s3_h_reg <= s2_h_reg;
        end
    end

    assign out_ctl = s3_ctl_reg;
    assign out_a   = s3_a_reg;
    assign out_b   = s3_b_reg;
    assign out_r   = s3_r_reg;
    assign out_w   = s3_w_reg;
    assign out_h   = s3_h_reg;

endmodule
